FILE: rtl/rtph_pkg.sv
// Shared constants and codes for the rack tooth profile height core.
package rtph_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int Q24_SHIFT  = 24 - FRAC_BITS;
   localparam int POS_W      = 32;
   localparam int HEIGHT_W   = 32;
   localparam int REGION_W   = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // floor(2^32 / pi), Q0.32
   localparam logic [30:0] INV_PI = 31'd1367130551;

   // Root digits produced by the fillet square root, one per cycle
   localparam int          SQRT_STEPS = 25;
   localparam logic [4:0]  SQRT_LAST  = 5'(SQRT_STEPS - 1);

   typedef enum logic [REGION_W-1:0] {
      REGION_HEAD   = 2'd0,
      REGION_FLANK  = 2'd1,
      REGION_FILLET = 2'd2,
      REGION_FOOT   = 2'd3
   } region_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MODULE_SIZE   = 3'd0,
      CSR_FLANK_BEGIN   = 3'd1,
      CSR_FILLET_BEGIN  = 3'd2,
      CSR_FILLET_CENTRE = 3'd3,
      CSR_FLANK_SLOPE   = 3'd4,
      CSR_FLANK_OFFSET  = 3'd5,
      CSR_FILLET_RADIUS = 3'd6,
      CSR_TIP_CLEARANCE = 3'd7
   } csr_index_type;

endpackage

FILE: rtl/rack_tooth_profile_height_core.sv
// Rack tooth profile height core: position along a gear rack in, tooth height and region out.
//
// Usage
//   req_*  : one item per position, Q16.16 signed, in module units.
//   rsp_*  : one item per position: height (Q16.16 signed, module scaled, floored and
//            saturated) in tdata, profile region (head, flank, root fillet, foot) in tuser.
//   csr_*  : register writes, taken on any edge with csr_wen high; write only while idle.
// Timing
//   One item is worked on at a time by a sequencer around a single shared 33x33 multiplier
//   and a bit-serial square root that produces one root bit a cycle. From accept to
//   result valid, head and foot pass MPOS, FRAC, MSCL and OUT; flank adds MFLK and FLK;
//   root fillet adds MR2, MD2, RAD, the 25 square root steps and FIL; OUT waits while the
//   output stalls. A new item is taken only in idle, entered as the result is registered.
// Reset
//   Synchronous, active high: sequencer to idle, output empty, configuration registers to their
//   reset values (module one, all others zero).
// Back pressure
//   The result waits in the output register; the next item is accepted and worked on
//   meanwhile, and the sequencer holds its finished result until the register drains.
module rack_tooth_profile_height_core (
   input  logic                              clock,
   input  logic                              reset,
   // input items
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rtph_pkg::POS_W-1:0]        req_tdata,   // [31:0] position
   // result items
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rtph_pkg::HEIGHT_W-1:0]     rsp_tdata,   // [31:0] height
   output logic [rtph_pkg::REGION_W-1:0]     rsp_tuser,   // [1:0] region
   // register writes
   input  logic                              csr_wen,
   input  logic [rtph_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [rtph_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rtph_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE = 12'b0000_0000_0001,
      S_MPOS = 12'b0000_0000_0010,
      S_FRAC = 12'b0000_0000_0100,
      S_MFLK = 12'b0000_0000_1000,
      S_FLK  = 12'b0000_0001_0000,
      S_MR2  = 12'b0000_0010_0000,
      S_MD2  = 12'b0000_0100_0000,
      S_RAD  = 12'b0000_1000_0000,
      S_SQRT = 12'b0001_0000_0000,
      S_FIL  = 12'b0010_0000_0000,
      S_MSCL = 12'b0100_0000_0000,
      S_OUT  = 12'b1000_0000_0000
   } state_type;

   // ---------------------------------------------------------------- registers
   state_type          state_ff, state_in;

   logic [30:0]        module_ff;
   logic [15:0]        flank_begin_ff;
   logic [15:0]        fillet_begin_ff;
   logic [15:0]        centre_ff;
   logic signed [31:0] slope_ff;
   logic signed [31:0] offset_ff;
   logic [16:0]        radius_ff;
   logic [16:0]        clear_ff;

   logic signed [31:0] pos_ff, pos_in;
   logic [31:0]        u_ff, u_in;
   logic [23:0]        d_ff, d_in;
   region_type         region_ff, region_in;
   logic signed [32:0] y_ff, y_in;
   logic signed [65:0] prod_ff, prod_in;
   logic [49:0]        rad_ff, rad_in;

   logic [49:0]        sq_rad_ff, sq_rad_in;
   logic [25:0]        sq_rem_ff, sq_rem_in;
   logic [24:0]        sq_root_ff, sq_root_in;
   logic [4:0]         cnt_ff, cnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_height_ff, rsp_height_in;
   region_type         rsp_region_ff, rsp_region_in;

   // ---------------------------------------------------------------- datapath
   logic signed [32:0] mul_a, mul_b;
   logic [31:0]        u_raw, u_fold;
   logic [31:0]        centre_q32, d_full;
   logic signed [50:0] rad_diff;
   logic [27:0]        rem_sh, trial;
   logic signed [18:0] fil_k, foot_k;
   logic signed [27:0] fil_q24, foot_q24;
   logic signed [49:0] h_full;
   logic [31:0]        h_sat;
   logic               out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_height_ff;
   assign rsp_tuser  = rsp_region_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Shared multiplier operands, steered by the sequencer
   always_comb begin
      case (state_ff)
         S_MPOS: begin
            mul_a = 33'(pos_ff);
            mul_b = signed'({2'b00, INV_PI});
         end
         S_MFLK: begin
            mul_a = 33'(slope_ff);
            mul_b = signed'({1'b0, u_ff});
         end
         S_MR2: begin
            mul_a = signed'({8'd0, radius_ff, 8'd0});
            mul_b = signed'({8'd0, radius_ff, 8'd0});
         end
         S_MD2: begin
            mul_a = signed'({9'd0, d_ff});
            mul_b = signed'({9'd0, d_ff});
         end
         S_MSCL, S_OUT: begin
            // keep the scaled height in the product register while the result waits
            mul_a = signed'({2'b00, module_ff});
            mul_b = y_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Pitch fraction in Q0.32; fold the upper half of the pitch, half pitch stays
   assign u_raw  = prod_ff[FRAC_BITS+31:FRAC_BITS];
   assign u_fold = (u_raw > 32'h8000_0000) ? (~u_raw + 32'd1) : u_raw;

   assign centre_q32 = {centre_ff, 16'h0000};
   assign d_full     = centre_q32 - u_fold;

   // Radicand r^2 - d^2, clamped at zero when the point lies beyond the radius
   assign rad_diff = signed'({1'b0, rad_ff}) - signed'({1'b0, prod_ff[49:0]});

   // One root bit per cycle: bring down two radicand bits, try subtracting 4*root+1
   assign rem_sh = {sq_rem_ff, sq_rad_ff[49:48]};
   assign trial  = {1'b0, sq_root_ff, 2'b01};

   // Fillet centre height c = radius - 1 - clearance, and the foot level -1 - clearance
   assign fil_k    = signed'({2'b00, radius_ff}) - 19'sd65536 - signed'({2'b00, clear_ff});
   assign foot_k   = -19'sd65536 - signed'({2'b00, clear_ff});
   assign fil_q24  = signed'({fil_k, 8'h00}) - signed'({3'b000, sq_root_ff});
   assign foot_q24 = signed'({foot_k, 8'h00});

   // Scale back by the module and clamp to the signed 32 bit range
   assign h_full = prod_ff[65:FRAC_BITS];
   always_comb begin
      if (!h_full[49] && (|h_full[48:31])) begin
         h_sat = 32'h7FFF_FFFF;
      end else if (h_full[49] && !(&h_full[48:31])) begin
         h_sat = 32'h8000_0000;
      end else begin
         h_sat = h_full[31:0];
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      u_in          = u_ff;
      d_in          = d_ff;
      region_in     = region_ff;
      y_in          = y_ff;
      rad_in        = rad_ff;
      sq_rad_in     = sq_rad_ff;
      sq_rem_in     = sq_rem_ff;
      sq_root_in    = sq_root_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_height_in = rsp_height_ff;
      rsp_region_in = rsp_region_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               pos_in   = signed'(req_tdata);
               state_in = S_MPOS;
            end
         end
         S_MPOS: begin
            state_in = S_FRAC;
         end
         S_FRAC: begin
            u_in = u_fold;
            d_in = d_full[31:8];
            if (u_fold < {flank_begin_ff, 16'h0000}) begin
               region_in = REGION_HEAD;
               y_in      = 33'sd1 <<< FRAC_BITS;
               state_in  = S_MSCL;
            end else if (u_fold < {fillet_begin_ff, 16'h0000}) begin
               region_in = REGION_FLANK;
               state_in  = S_MFLK;
            end else if (u_fold < centre_q32) begin
               region_in = REGION_FILLET;
               state_in  = S_MR2;
            end else begin
               region_in = REGION_FOOT;
               y_in      = 33'(foot_q24 >>> Q24_SHIFT);
               state_in  = S_MSCL;
            end
         end
         S_MFLK: begin
            state_in = S_FLK;
         end
         S_FLK: begin
            y_in     = prod_ff[64:32] + 33'(offset_ff);
            state_in = S_MSCL;
         end
         S_MR2: begin
            state_in = S_MD2;
         end
         S_MD2: begin
            rad_in   = prod_ff[49:0];
            state_in = S_RAD;
         end
         S_RAD: begin
            sq_rad_in  = rad_diff[50] ? 50'd0 : rad_diff[49:0];
            sq_rem_in  = '0;
            sq_root_in = '0;
            cnt_in     = '0;
            state_in   = S_SQRT;
         end
         S_SQRT: begin
            sq_rad_in = {sq_rad_ff[47:0], 2'b00};
            if (rem_sh >= trial) begin
               sq_rem_in  = 26'(rem_sh - trial);
               sq_root_in = {sq_root_ff[23:0], 1'b1};
            end else begin
               sq_rem_in  = rem_sh[25:0];
               sq_root_in = {sq_root_ff[23:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == SQRT_LAST) begin
               state_in = S_FIL;
            end
         end
         S_FIL: begin
            y_in     = 33'(fil_q24 >>> Q24_SHIFT);
            state_in = S_MSCL;
         end
         S_MSCL: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold the result until the output register can take it
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_height_in = h_sat;
               rsp_region_in = region_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      u_ff          <= u_in;
      d_ff          <= d_in;
      region_ff     <= region_in;
      y_ff          <= y_in;
      prod_ff       <= prod_in;
      rad_ff        <= rad_in;
      sq_rad_ff     <= sq_rad_in;
      sq_rem_ff     <= sq_rem_in;
      sq_root_ff    <= sq_root_in;
      rsp_height_ff <= rsp_height_in;
      rsp_region_ff <= rsp_region_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         module_ff       <= 31'd65536;
         flank_begin_ff  <= '0;
         fillet_begin_ff <= '0;
         centre_ff       <= '0;
         slope_ff        <= '0;
         offset_ff       <= '0;
         radius_ff       <= '0;
         clear_ff        <= '0;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_addr))
            CSR_MODULE_SIZE:   module_ff       <= csr_wdata[30:0];
            CSR_FLANK_BEGIN:   flank_begin_ff  <= csr_wdata[15:0];
            CSR_FILLET_BEGIN:  fillet_begin_ff <= csr_wdata[15:0];
            CSR_FILLET_CENTRE: centre_ff       <= csr_wdata[15:0];
            CSR_FLANK_SLOPE:   slope_ff        <= signed'(csr_wdata);
            CSR_FLANK_OFFSET:  offset_ff       <= signed'(csr_wdata);
            CSR_FILLET_RADIUS: radius_ff       <= csr_wdata[16:0];
            CSR_TIP_CLEARANCE: clear_ff        <= csr_wdata[16:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- checks
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_MPOS))
      else $error("accepted item did not start the multiply");

   a_sqrt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQRT) |-> (cnt_ff <= SQRT_LAST))
      else $error("square root step count overran");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && !rsp_tready) |=> (state_ff == S_OUT))
      else $error("result dropped while output stalled");

   a_head_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MSCL && region_ff == REGION_HEAD) |-> (y_ff == (33'sd1 <<< FRAC_BITS)))
      else $error("head region not at unit height");

   a_fillet_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIL) |-> ($past(state_ff) == S_SQRT && region_ff == REGION_FILLET))
      else $error("fillet result without square root");

endmodule
